FILE: hdl/arll_pkg.sv
// ----------------------------------------------------------------------------
// arll_pkg: shared types and constants of the auto ranging lux core
// Field widths, status and register codes, sequencer states, and the
// conversion denominator table.
// ----------------------------------------------------------------------------
`default_nettype none

package arll_pkg;

    localparam int COUNT_W  = 16;
    localparam int LUX_W    = 32;
    localparam int STATUS_W = 3;
    localparam int GAIN_W   = 2;
    localparam int TIME_W   = 3;
    localparam int INDEX_W  = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;

    // 10*full - 17*ir spans 22 signed bits, its magnitude 21
    localparam int DIFF_W = 22;
    localparam int MAG_W  = 21;
    localparam int PROD_W = 30;
    localparam int FRAC_W = 12;
    localparam int NUM_W  = PROD_W + FRAC_W;
    localparam int DEN_W  = 26;

    localparam logic [COUNT_W-1:0] SAT_COUNT  = 16'hFFFF;
    localparam logic [COUNT_W-1:0] DARK_LIMIT = 16'h0010;
    localparam logic [8:0]         LUX_SCALE  = 9'd408;

    localparam logic [INDEX_W-1:0] LAST_INDEX  = 5'd23;
    localparam logic [INDEX_W-1:0] START_INDEX = 5'd6;
    localparam logic [TIME_W-1:0]  LAST_TIME   = 3'd5;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_VALID      = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_BRIGHT_FIN = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_DARK_FIN   = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_STEP_DOWN  = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_STEP_UP    = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_TIME = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [GAIN_W-1:0]   gain;
        logic [TIME_W-1:0]   itime;
        logic                good;
    } t_decision;

    // 1000 * gain * (time + 1): the ms scale and the factor 10 of the 1.7 weight
    function automatic logic [DEN_W-1:0] den_of(input logic [GAIN_W-1:0] g,
                                                input logic [TIME_W-1:0] t);
        logic [DEN_W-1:0] base;
        logic [DEN_W-1:0] mult;
        begin
            case (g)
                2'd0:    base = 26'd1000;
                2'd1:    base = 26'd25000;
                2'd2:    base = 26'd428000;
                default: base = 26'd9876000;
            endcase
            mult = {{(DEN_W-TIME_W){1'b0}}, t} + 26'd1;
            den_of = DEN_W'(base * mult);
        end
    endfunction

endpackage

`default_nettype wire

FILE: hdl/auto_ranging_light_lux_core.sv
// ----------------------------------------------------------------------------
// auto_ranging_light_lux_core: lux from two light counts with auto ranging
// Input channel takes a full spectrum and an infrared count; output channel
// gives lux in signed Q12, a status and the gain and time for the next read.
// A good reading goes from acceptance to the output register through the
// states S_MUL (difference and scale multiply, divider start), S_DIV (the
// restoring divider, one quotient bit per cycle, then sign and saturation)
// and S_OUT (handoff). A bright or dark reading skips the divider and goes
// from acceptance straight to S_OUT.
// A new word is accepted once the previous one has left the sequencer, so
// the block never takes a new word before it is through with the last. The
// result sits in an output register; a stall there holds it, and the
// sequencer waits with its next result until the register is free.
// The configuration port is always ready; write it only while the block is
// idle. Synchronous active low reset restores auto off, manual gain 25x,
// manual time 200 ms and the range index to gain 25x at 100 ms.
// ----------------------------------------------------------------------------
`default_nettype none

module auto_ranging_light_lux_core
    import arll_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [COUNT_W-1:0]    i_full_count,
    input  wire logic [COUNT_W-1:0]    i_infrared_count,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic signed [LUX_W-1:0]    o_lux_q12,
    output logic [STATUS_W-1:0]        o_status,
    output logic [GAIN_W-1:0]          o_gain_code,
    output logic [TIME_W-1:0]          o_time_code
);

    t_state               r_state;
    t_state               n_state;
    t_decision            decision;

    logic                 accept;
    logic                 div_start;
    logic                 div_done;
    logic [NUM_W-1:0]     quotient;

    logic [COUNT_W-1:0]   r_full;
    logic [COUNT_W-1:0]   r_ir;
    logic [STATUS_W-1:0]  r_status;
    logic [GAIN_W-1:0]    r_gain;
    logic [TIME_W-1:0]    r_time;
    logic                 r_neg;
    logic [LUX_W-1:0]     r_lux;

    logic                 r_out_valid;
    logic [LUX_W-1:0]     r_out_lux;
    logic [STATUS_W-1:0]  r_out_status;
    logic [GAIN_W-1:0]    r_out_gain;
    logic [TIME_W-1:0]    r_out_time;

    logic                 out_free;
    logic                 load_out;
    logic signed [DIFF_W-1:0] diff;
    logic [MAG_W-1:0]     mag;
    logic [PROD_W-1:0]    prod;
    logic                 sat_pos;
    logic                 sat_neg;
    logic [LUX_W-1:0]     lux_signed;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign accept      = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;

    arll_range u_range (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_write      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_step           (accept),
        .i_full_count     (i_full_count),
        .i_infrared_count (i_infrared_count),
        .o_decision       (decision)
    );

    // (10*full - 17*ir) * 408, the 4096 of Q12 enters as zero low bits
    always_comb begin
        diff = DIFF_W'($signed({1'b0, r_full}) * 22'sd10)
             - DIFF_W'($signed({1'b0, r_ir}) * 22'sd17);
        mag  = diff[DIFF_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
        prod = PROD_W'(mag) * PROD_W'(LUX_SCALE);
    end

    arll_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_num      ({prod, {FRAC_W{1'b0}}}),
        .i_den      (den_of(r_gain, r_time)),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    always_comb begin
        sat_pos    = (quotient[NUM_W-1:LUX_W-1] != '0);
        sat_neg    = (quotient[NUM_W-1:LUX_W] != '0) ||
                     (quotient[LUX_W-1] && (quotient[LUX_W-2:0] != '0));
        if (r_neg) begin
            lux_signed = sat_neg ? {1'b1, {(LUX_W-1){1'b0}}}
                                 : LUX_W'(-quotient[LUX_W-1:0]);
        end else begin
            lux_signed = sat_pos ? {1'b0, {(LUX_W-1){1'b1}}} : quotient[LUX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        load_out  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = decision.good ? S_MUL : S_OUT;
                end
            end
            S_MUL: begin
                div_start = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // job registers: capture the word and decision, then the sign, then the signed lux
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_full   <= i_full_count;
            r_ir     <= i_infrared_count;
            r_status <= decision.status;
            r_gain   <= decision.gain;
            r_time   <= decision.itime;
            r_lux    <= '0;
        end else if (r_state == S_MUL) begin
            r_neg <= diff[DIFF_W-1];
        end else if (r_state == S_DIV && div_done) begin
            r_lux <= lux_signed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_lux    <= r_lux;
            r_out_status <= r_status;
            r_out_gain   <= r_gain;
            r_out_time   <= r_time;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_lux_q12   = $signed(r_out_lux);
    assign o_status    = r_out_status;
    assign o_gain_code = r_out_gain;
    assign o_time_code = r_out_time;

endmodule

`default_nettype wire

FILE: hdl/arll_div.sv
// ----------------------------------------------------------------------------
// arll_div: iterative restoring divider
// One shared subtract and compare, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module arll_div
    import arll_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_done,
    output logic [NUM_W-1:0]      o_quotient
);

    localparam int CNT_W = $clog2(NUM_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [DEN_W:0]       r_rem;
    logic [NUM_W-1:0]     r_num;
    logic [DEN_W-1:0]     r_den;

    logic [DEN_W:0]       trial;
    logic                 fits;
    logic [DEN_W:0]       diff;

    always_comb begin
        trial = {r_rem[DEN_W-1:0], r_num[NUM_W-1]};
        fits  = (trial >= {1'b0, r_den});
        diff  = trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // numerator bits leave at the top, quotient bits enter at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_num <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= fits ? diff : trial;
            r_num <= {r_num[NUM_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_num;

endmodule

`default_nettype wire

FILE: hdl/arll_range.sv
// ----------------------------------------------------------------------------
// arll_range: configuration registers and range control
// Classifies a reading, steps the range index in auto mode and picks the
// gain and time settings of the reading.
// ----------------------------------------------------------------------------
`default_nettype none

module arll_range
    import arll_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_step,
    input  wire logic [COUNT_W-1:0]    i_full_count,
    input  wire logic [COUNT_W-1:0]    i_infrared_count,
    output t_decision                  o_decision
);

    logic                 r_auto;
    logic [GAIN_W-1:0]    r_manual_gain;
    logic [TIME_W-1:0]    r_manual_time;
    logic [INDEX_W-1:0]   r_index;
    logic [INDEX_W-1:0]   n_index;

    logic                 bright;
    logic                 dark;
    logic [INDEX_W-1:0]   idx;
    logic [GAIN_W-1:0]    idx_gain;
    logic [INDEX_W-1:0]   idx_base;

    always_comb begin
        bright = (i_full_count == SAT_COUNT) || (i_infrared_count == SAT_COUNT);
        dark   = !bright &&
                 ((i_full_count < DARK_LIMIT) || (i_infrared_count < DARK_LIMIT));

        idx = (r_index > LAST_INDEX) ? LAST_INDEX : r_index;
        o_decision.status = STAT_VALID;
        o_decision.good   = 1'b0;

        if (r_auto) begin
            if (bright) begin
                if (idx == '0) begin
                    o_decision.status = STAT_BRIGHT_FIN;
                end else begin
                    idx = idx - 1'b1;
                    o_decision.status = STAT_STEP_DOWN;
                end
            end else if (dark) begin
                if (idx == LAST_INDEX) begin
                    o_decision.status = STAT_DARK_FIN;
                end else begin
                    idx = idx + 1'b1;
                    o_decision.status = STAT_STEP_UP;
                end
            end else begin
                o_decision.good = 1'b1;
            end
        end else begin
            if (bright) begin
                o_decision.status = STAT_BRIGHT_FIN;
            end else if (dark) begin
                o_decision.status = STAT_DARK_FIN;
            end else begin
                o_decision.good = 1'b1;
            end
        end
        n_index = idx;

        // gain is the index over six, time the remainder
        if (idx < 5'd6) begin
            idx_gain = 2'd0;
            idx_base = 5'd0;
        end else if (idx < 5'd12) begin
            idx_gain = 2'd1;
            idx_base = 5'd6;
        end else if (idx < 5'd18) begin
            idx_gain = 2'd2;
            idx_base = 5'd12;
        end else begin
            idx_gain = 2'd3;
            idx_base = 5'd18;
        end

        if (r_auto) begin
            o_decision.gain  = idx_gain;
            o_decision.itime = TIME_W'(idx - idx_base);
        end else begin
            o_decision.gain  = r_manual_gain;
            o_decision.itime = (r_manual_time > LAST_TIME) ? LAST_TIME : r_manual_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto        <= 1'b0;
            r_manual_gain <= 2'd1;
            r_manual_time <= 3'd1;
            r_index       <= START_INDEX;
        end else if (i_cfg_write) begin
            unique case (i_cfg_index)
                CFG_AUTO_ENABLE: begin
                    // entering auto restarts from the start range, gain 25x at 100 ms
                    if (i_cfg_data[0] && !r_auto) begin
                        r_index <= START_INDEX;
                    end
                    r_auto <= i_cfg_data[0];
                end
                CFG_MANUAL_GAIN: r_manual_gain <= i_cfg_data[GAIN_W-1:0];
                CFG_MANUAL_TIME: r_manual_time <= i_cfg_data[TIME_W-1:0];
                default: ;
            endcase
        end else if (i_step && r_auto) begin
            r_index <= n_index;
        end
    end

endmodule

`default_nettype wire

FILE: tb/tb_auto_ranging_light_lux_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_auto_ranging_light_lux_core: self-checking bench for the lux core
// Feeds pairs of light counts under manual and auto ranging settings, keeps
// its own model of the range index and registers, and checks every result
// word field by field. Both sides idle in short random bursts, and once the
// receiver holds off long enough to back the block up to its input.
// ----------------------------------------------------------------------------

module tb_auto_ranging_light_lux_core;
    import arll_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam longint unsigned LUX_NUM = 64'd408 * 64'd4096;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 154;
    localparam int IDLE_PAD    = 60;
    localparam int HOLD_AT     = 100;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic [COUNT_W-1:0] full;
        logic [COUNT_W-1:0] ir;
    } t_reading;

    typedef struct {
        logic signed [LUX_W-1:0] lux;
        logic [STATUS_W-1:0]     status;
        logic [GAIN_W-1:0]       gain;
        logic [TIME_W-1:0]       itime;
    } t_lux_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic [COUNT_W-1:0] i_full_count = '0;
    logic [COUNT_W-1:0] i_infrared_count = '0;
    logic i_out_stall = 1'b0;
    logic o_cfg_ready;
    logic o_in_stall;
    logic o_out_valid;
    logic signed [LUX_W-1:0] o_lux_q12;
    logic [STATUS_W-1:0] o_status;
    logic [GAIN_W-1:0] o_gain_code;
    logic [TIME_W-1:0] o_time_code;

    // model of the block's registers and range index
    logic               mdl_auto = 1'b0;
    logic [GAIN_W-1:0]  mdl_gain = 2'd1;
    logic [TIME_W-1:0]  mdl_time = 3'd1;
    logic [INDEX_W-1:0] mdl_range = START_INDEX;

    t_reading    reading_q[$];
    t_lux_result lux_expect_q[$];
    int unsigned fail_cnt = 0;
    int unsigned accepted_cnt = 0;
    logic        in_taken = 1'b0;
    int          gap_left = 0;
    int          stall_left = 0;
    int          hold_left = 0;
    logic        hold_done = 1'b0;
    logic        quiet_tail = 1'b0;

    auto_ranging_light_lux_core u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_full_count     (i_full_count),
        .i_infrared_count (i_infrared_count),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_lux_q12        (o_lux_q12),
        .o_status         (o_status),
        .o_gain_code      (o_gain_code),
        .o_time_code      (o_time_code)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic signed [LUX_W-1:0] lux_from_counts(
        input logic [COUNT_W-1:0] full, input logic [COUNT_W-1:0] ir,
        input logic [GAIN_W-1:0] g, input logic [TIME_W-1:0] t);
        longint diff;
        longint unsigned gmul;
        longint unsigned mag;
        longint unsigned den;
        longint unsigned q;
        case (g)
            2'd0:    gmul = 1;
            2'd1:    gmul = 25;
            2'd2:    gmul = 428;
            default: gmul = 9876;
        endcase
        diff = longint'(full) * 10 - longint'(ir) * 17;
        mag = (diff < 0) ? longint'(-diff) : longint'(diff);
        den = gmul * (longint'(t) + 1) * 1000;
        q = (mag * LUX_NUM) / den;
        if (diff < 0) begin
            if (q > 64'd2147483648) q = 64'd2147483648;
            return LUX_W'(-longint'(q));
        end
        if (q > 64'd2147483647) q = 64'd2147483647;
        return LUX_W'(q);
    endfunction

    // work out one result word and advance the range index
    function automatic t_lux_result predict_result(input t_reading rd);
        t_lux_result res;
        logic bright;
        logic dark;
        int idx;
        bright = (rd.full == SAT_COUNT) || (rd.ir == SAT_COUNT);
        dark = !bright && ((rd.full < DARK_LIMIT) || (rd.ir < DARK_LIMIT));
        res.lux = '0;
        res.status = STAT_VALID;
        if (mdl_auto) begin
            idx = (mdl_range > LAST_INDEX) ? int'(LAST_INDEX) : int'(mdl_range);
            if (bright) begin
                if (idx == 0) res.status = STAT_BRIGHT_FIN;
                else begin
                    idx--;
                    res.status = STAT_STEP_DOWN;
                end
            end else if (dark) begin
                if (idx == int'(LAST_INDEX)) res.status = STAT_DARK_FIN;
                else begin
                    idx++;
                    res.status = STAT_STEP_UP;
                end
            end else begin
                res.lux = lux_from_counts(rd.full, rd.ir, GAIN_W'(idx / 6), TIME_W'(idx % 6));
            end
            mdl_range = INDEX_W'(idx);
            res.gain = GAIN_W'(idx / 6);
            res.itime = TIME_W'(idx % 6);
        end else begin
            res.gain = mdl_gain;
            res.itime = (mdl_time > LAST_TIME) ? LAST_TIME : mdl_time;
            if (bright) res.status = STAT_BRIGHT_FIN;
            else if (dark) res.status = STAT_DARK_FIN;
            else res.lux = lux_from_counts(rd.full, rd.ir, res.gain, res.itime);
        end
        return res;
    endfunction

    function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_AUTO_ENABLE: begin
                // entering auto restarts the range at START_INDEX
                if (data[0] && !mdl_auto) mdl_range = START_INDEX;
                mdl_auto = data[0];
            end
            CFG_MANUAL_GAIN: mdl_gain = data[GAIN_W-1:0];
            CFG_MANUAL_TIME: mdl_time = data;
            default: ;
        endcase
    endfunction

    // monitor, checker and predictor
    always @(posedge i_clk) begin
        t_lux_result exp_res;
        t_reading rd;
        in_taken <= i_in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) apply_reg_write(i_cfg_index, i_cfg_data);
            if (o_out_valid && !i_out_stall) begin
                if (lux_expect_q.size() == 0) begin
                    $error("unexpected result word: lux_q12=%0d status=%0d", o_lux_q12,
                           o_status);
                    fail_cnt++;
                end else begin
                    exp_res = lux_expect_q.pop_front();
                    if (o_lux_q12 !== exp_res.lux) begin
                        $error("lux_q12: expected %0d, got %0d", exp_res.lux, o_lux_q12);
                        fail_cnt++;
                    end
                    if (o_status !== exp_res.status) begin
                        $error("status: expected %0d, got %0d", exp_res.status, o_status);
                        fail_cnt++;
                    end
                    if (o_gain_code !== exp_res.gain) begin
                        $error("gain_code: expected %0d, got %0d", exp_res.gain,
                               o_gain_code);
                        fail_cnt++;
                    end
                    if (o_time_code !== exp_res.itime) begin
                        $error("time_code: expected %0d, got %0d", exp_res.itime,
                               o_time_code);
                        fail_cnt++;
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                rd.full = i_full_count;
                rd.ir = i_infrared_count;
                lux_expect_q.push_back(predict_result(rd));
                accepted_cnt++;
            end
        end
    end

    // input driver: hold the word until taken, then advance or idle
    always @(negedge i_clk) begin
        t_reading nxt;
        if (!i_in_valid || in_taken) begin
            if (gap_left != 0) begin
                i_in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (reading_q.size() != 0) begin
                nxt = reading_q.pop_front();
                i_in_valid <= 1'b1;
                i_full_count <= nxt.full;
                i_infrared_count <= nxt.ir;
                if (!quiet_tail && $urandom_range(0, 5) == 0)
                    gap_left <= $urandom_range(1, 4);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // one long receiver hold-off so the block backs up
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && accepted_cnt >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
        end else if (quiet_tail) begin
            i_out_stall <= 1'b0;
        end else if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 7) == 0) begin
            i_out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 3);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic add_reading(input int full, input int ir);
        t_reading rd;
        rd.full = COUNT_W'(full);
        rd.ir = COUNT_W'(ir);
        reading_q.push_back(rd);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (reading_q.size() != 0 || i_in_valid || lux_expect_q.size() != 0)
            @(negedge i_clk);
        repeat (IDLE_PAD) @(negedge i_clk);
    endtask

    // runs of bright, dark, good and random readings so auto mode walks the whole range
    task automatic queue_readings(input int n);
        int left;
        int run;
        int kind;
        int a;
        int b;
        left = n;
        while (left > 0) begin
            kind = $urandom_range(0, 9);
            run = (kind < 4) ? $urandom_range(1, 30) : $urandom_range(1, 8);
            if (run > left) run = left;
            repeat (run) begin
                case (kind)
                    0, 1: begin
                        a = 65535;
                        b = $urandom_range(0, 65535);
                    end
                    2, 3: begin
                        a = $urandom_range(0, 15);
                        b = $urandom_range(0, 65534);
                    end
                    9: begin
                        a = $urandom_range(0, 65535);
                        b = $urandom_range(0, 65535);
                    end
                    default: begin
                        a = $urandom_range(16, 65534);
                        case ($urandom_range(0, 3))
                            0: b = $urandom_range(16, 65534);
                            1: b = $urandom_range(16, 64);
                            2: begin
                                a = $urandom_range(16, 300);
                                b = $urandom_range(16, 300);
                            end
                            default: begin
                                b = (a * 10) / 17 + $urandom_range(0, 8) - 4;
                                if (b < 16) b = 16;
                            end
                        endcase
                    end
                endcase
                if ($urandom_range(0, 1)) add_reading(a, b);
                else add_reading(b, a);
            end
            left -= run;
        end
    endtask

    initial begin
        bit auto_plan[PHASES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // manual mode at reset settings: boundaries and bright/dark overlap
        add_reading(0, 0);
        add_reading(65535, 65535);
        add_reading(65535, 3);
        add_reading(3, 65535);
        add_reading(16, 16);
        add_reading(15, 16);
        add_reading(16, 15);
        add_reading(65534, 16);
        add_reading(16, 65534);
        add_reading(1700, 1000);
        add_reading(1000, 588);
        wait_idle();

        // smallest denominator gives the largest lux magnitudes
        write_reg(CFG_MANUAL_GAIN, 3'd0);
        write_reg(CFG_MANUAL_TIME, 3'd0);
        @(posedge i_clk);
        add_reading(65534, 16);
        add_reading(16, 65534);
        wait_idle();

        // out of range time codes clamp to 600 ms
        write_reg(CFG_MANUAL_GAIN, 3'd7);
        write_reg(CFG_MANUAL_TIME, 3'd7);
        @(posedge i_clk);
        add_reading(65534, 16);
        add_reading(16, 16);
        wait_idle();
        write_reg(CFG_MANUAL_TIME, 3'd6);
        write_reg(CFG_UNUSED, 3'd7);
        @(posedge i_clk);
        add_reading(40000, 20000);
        wait_idle();

        // enter auto: one step down, one step up, then a good reading
        write_reg(CFG_AUTO_ENABLE, 3'd1);
        @(posedge i_clk);
        add_reading(65535, 100);
        add_reading(100, 5);
        add_reading(3000, 1200);
        wait_idle();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    write_reg(CFG_MANUAL_GAIN, 3'd0);
                    write_reg(CFG_MANUAL_TIME, 3'd0);
                end
                3: begin
                    write_reg(CFG_MANUAL_GAIN, 3'd3);
                    write_reg(CFG_MANUAL_TIME, 3'd5);
                end
                default: begin
                    write_reg(CFG_MANUAL_GAIN, 3'($urandom_range(0, 7)));
                    write_reg(CFG_MANUAL_TIME, 3'($urandom_range(0, 7)));
                end
            endcase
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_UNUSED, 3'($urandom_range(0, 7)));
            write_reg(CFG_AUTO_ENABLE, {2'($urandom_range(0, 3)), auto_plan[p]});
            @(posedge i_clk);
            if (p == PHASES - 1) quiet_tail = 1'b1;
            queue_readings(PHASE_ITEMS);
            wait_idle();
        end

        if (fail_cnt == 0 && lux_expect_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
